// ----- design/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// SwiGLU activation package
// Shared widths and the per-stage load enables of the datapath pipeline.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int DATA_W     = 16;   // Q8.8 data and gate scale
    localparam int ARG_W      = 32;   // gate * scale, Q16.16
    localparam int CLAMP_W    = 20;   // clamped sigmoid argument, [-8, 8) in Q4.16
    localparam int SIG_W      = 16;   // sigmoid value, unsigned Q0.16
    localparam int GL_W       = 32;   // gate * linear, Q16.16
    localparam int PROD_W     = 48;   // gate * sigmoid * linear, Q16.32
    localparam int ROUND_SH   = 24;   // Q16.32 -> Q8.8
    localparam int NUM_STAGES = 5;

    typedef logic signed [DATA_W-1:0] t_q88;

    // one load enable per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

// ----- design/swa_arg_stage.sv -----
// ----------------------------------------------------------------------------
// SwiGLU sigmoid argument stages
// Stage 1 scales the gate, stage 2 clamps to [-8, 8) and forms the table index.
// ----------------------------------------------------------------------------
module swa_arg_stage
    import swa_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = 256,
    parameter int IDX_W               = $clog2(SIGMOID_TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  t_q88             i_gate,
    input  t_q88             i_scale,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(SIGMOID_TABLE_DEPTH);

    logic signed [ARG_W-1:0]    r_p;
    logic [IDX_W-1:0]           r_idx;
    logic                       w_hi;
    logic                       w_lo;
    logic [CLAMP_W-1:0]         w_off;
    logic [CLAMP_W+IDX_W:0]     w_scaled;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p <= i_gate * i_scale;
        end
    end

    // clamp, then offset by +8 so the argument is unsigned in [0, 2^20)
    always_comb begin
        w_hi = !r_p[ARG_W-1] && (r_p[ARG_W-2:CLAMP_W-1] != '0);
        w_lo = r_p[ARG_W-1] && (r_p[ARG_W-2:CLAMP_W-1] != '1);
        if (w_hi) begin
            w_off = '1;
        end else if (w_lo) begin
            w_off = '0;
        end else begin
            w_off = {~r_p[CLAMP_W-1], r_p[CLAMP_W-2:0]};
        end
        w_scaled = (CLAMP_W+IDX_W+1)'(w_off) * (CLAMP_W+IDX_W+1)'(DEPTH_L);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_idx <= w_scaled[CLAMP_W+IDX_W-1:CLAMP_W];
        end
    end

    assign o_idx = r_idx;

endmodule

// ----- design/swa_sig_rom.sv -----
// ----------------------------------------------------------------------------
// SwiGLU sigmoid table
// Constant table of sigmoid(x), x = -8 + 16*i/DEPTH, built at elaboration;
// registered read in stage 3.
// ----------------------------------------------------------------------------
module swa_sig_rom
    import swa_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = 256,
    parameter int IDX_W               = $clog2(SIGMOID_TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [IDX_W-1:0] i_idx,
    output logic [SIG_W-1:0] o_sig
);

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int          TERMS   = 20;

    // shift-subtract divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [SIG_W-1:0] sigmoid_entry(input int unsigned i);
        logic [63:0] twice;
        logic [63:0] depth;
        logic [63:0] span;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        longint      sum;
        twice = 64'(i) << 1;
        depth = 64'(SIGMOID_TABLE_DEPTH);
        span  = (twice >= depth) ? twice - depth : depth - twice;
        u     = udiv64(span << 30, depth);
        term  = ONE_Q30;
        sum   = longint'(ONE_Q30);
        // e^-u by Taylor series, alternating signs
        for (int n = 1; n <= TERMS; n++) begin
            term = udiv64((term * u) >> 30, 64'(n));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 1) begin
            sum = 1;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        e = 64'(sum);
        // e^-8u by three squarings
        for (int k = 0; k < 3; k++) begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        den = ONE_Q30 + e;
        s   = udiv64((64'd1 << 46) + (den >> 1), den);
        if (twice < depth) begin
            s = 64'd65536 - s;
        end
        return s[SIG_W-1:0];
    endfunction

    logic [SIG_W-1:0] w_rom [SIGMOID_TABLE_DEPTH];
    logic [SIG_W-1:0] r_sig;

    for (genvar gi = 0; gi < SIGMOID_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [SIG_W-1:0] ENTRY = sigmoid_entry(gi);
        assign w_rom[gi] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sig <= w_rom[i_idx];
        end
    end

    assign o_sig = r_sig;

endmodule

// ----- design/swa_out_stage.sv -----
// ----------------------------------------------------------------------------
// SwiGLU product and output stages
// gate * linear, times the sigmoid, then round half up and saturate to Q8.8.
// ----------------------------------------------------------------------------
module swa_out_stage
    import swa_pkg::*;
(
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  t_q88             i_gate,
    input  t_q88             i_linear,
    input  logic [SIG_W-1:0] i_sig,
    output t_q88             o_result,
    output logic             o_sat
);

    localparam int Q_W = PROD_W - ROUND_SH;

    t_q88                     r_gate;
    t_q88                     r_linear;
    logic signed [GL_W-1:0]   r_gl;
    logic signed [GL_W-1:0]   r_gl_d;
    logic signed [PROD_W-1:0] r_prod;
    t_q88                     r_result;
    logic                     r_sat;

    logic signed [SIG_W:0]    w_sig_s;
    logic signed [PROD_W-1:0] w_round;
    logic signed [Q_W-1:0]    w_q;
    t_q88                     n_result;
    logic                     n_sat;

    assign w_sig_s = $signed({1'b0, i_sig});

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_gate   <= i_gate;
            r_linear <= i_linear;
        end
        if (i_en.s2) begin
            r_gl <= r_gate * r_linear;
        end
        if (i_en.s3) begin
            r_gl_d <= r_gl;
        end
        if (i_en.s4) begin
            r_prod <= r_gl_d * w_sig_s;
        end
        if (i_en.s5) begin
            r_result <= n_result;
            r_sat    <= n_sat;
        end
    end

    // |product| < 2^46, so the rounding add cannot overflow
    always_comb begin
        w_round = r_prod + (PROD_W'(1) <<< (ROUND_SH - 1));
        w_q     = w_round[PROD_W-1:ROUND_SH];
        n_sat   = (w_q[Q_W-1:DATA_W-1] != '0) && (w_q[Q_W-1:DATA_W-1] != '1);
        if (!n_sat) begin
            n_result = w_q[DATA_W-1:0];
        end else if (w_q[Q_W-1]) begin
            n_result = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_result = r_result;
    assign o_sat    = r_sat;

endmodule

// ----- design/swiglu_activation_unit.sv -----
// ----------------------------------------------------------------------------
// SwiGLU activation unit
// gate * sigmoid(alpha * gate) * linear on signed Q8.8 streams.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one beat
// per input beat, in order, through five register stages. The five pipeline
// stages are the gate scaling
// multiply, the clamp and table index, the registered sigmoid table read, the
// three-way product, and round/saturate into the output register. Each stage
// loads when it is empty or the stage after it moves, so bubbles close up and
// input is taken while the output beat waits. The sigmoid table is a constant
// built at elaboration; there is no warm-up after reset. gate_scale (alpha,
// Q8.8, reset 1.0) is written on the cfg channel, which is always ready, and
// must only change while the pipeline is empty.
module swiglu_activation_unit
    import swa_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: gate_scale
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] gate_value, [31:16] linear_value
    input  logic        i_s_tlast,   // last_element
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] result_value
    output logic        o_m_tuser,   // [0] saturated
    output logic        o_m_tlast    // last_result
);

    localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);

    t_q88                    r_gate_scale;
    logic [NUM_STAGES:1]     r_v;
    logic [NUM_STAGES:1]     r_last;
    logic [NUM_STAGES+1:1]   w_rdy;
    t_stage_en               w_en;
    logic [IDX_W-1:0]        w_idx;
    logic [SIG_W-1:0]        w_sig;
    t_q88                    w_result;
    logic                    w_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_scale <= t_q88'(256);
        end else if (i_cfg_valid) begin
            r_gate_scale <= i_cfg_data;
        end
    end

    // a stage loads when empty or when the next one moves
    always_comb begin
        w_rdy[NUM_STAGES+1] = i_m_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign w_en = '{s1: w_rdy[1], s2: w_rdy[2], s3: w_rdy[3], s4: w_rdy[4], s5: w_rdy[5]};
    assign o_s_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_last[1] <= i_s_tlast;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    swa_arg_stage #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
        .IDX_W               (IDX_W)
    ) u_arg (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_gate  (i_s_tdata[15:0]),
        .i_scale (r_gate_scale),
        .o_idx   (w_idx)
    );

    swa_sig_rom #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
        .IDX_W               (IDX_W)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_idx (w_idx),
        .o_sig (w_sig)
    );

    swa_out_stage u_out (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_gate   (i_s_tdata[15:0]),
        .i_linear (i_s_tdata[31:16]),
        .i_sig    (w_sig),
        .o_result (w_result),
        .o_sat    (w_sat)
    );

    assign o_m_tvalid = r_v[NUM_STAGES];
    assign o_m_tdata  = w_result;
    assign o_m_tuser  = w_sat;
    assign o_m_tlast  = r_last[NUM_STAGES];

`ifndef SYNTHESIS
    // a saturated result sits on one of the two Q8.8 bounds
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 16'h7fff || o_m_tdata == 16'h8000))
        else $error("saturated result not at a bound");

    // input back-pressure only with every stage occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v))
        else $error("input stalled with a free stage");

    // an accepted beat lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[1])
        else $error("accepted beat lost at stage 1");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SwiGLU activation unit testbench
// Streams gate/linear beats through the unit under several gate_scale settings
// and checks each output beat against a directed value or a bit-exact Q8.8 model.
// ----------------------------------------------------------------------------
module testbench
    import swa_pkg::*;
();

    localparam int    SIG_DEPTH  = 256;
    localparam longint ARG_LO    = -524288;
    localparam longint ARG_HI    = 524287;
    localparam int    PHASE_LEN  = 100;
    localparam int    CYCLE_CAP  = 1000000;
    localparam int    SETTLE_CYC = 12;
    localparam int    HOLD_CYC   = 400;

    typedef struct {
        t_q88 value;
        logic sat;
        logic last;
    } t_act_beat;

    typedef struct {
        t_q88 scale;
        t_q88 gate;
        t_q88 lin;
        logic last;
        bit   typed;
        t_q88 res;
        logic sat;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    logic [15:0] sigmoid_rom [SIG_DEPTH];
    t_q88        gate_scale_q = 16'sd256;
    t_act_beat   pending_results[$];
    t_stim_row   directed_rows[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    swiglu_activation_unit #(
        .SIGMOID_TABLE_DEPTH(SIG_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sigmoid table: e^-|x| by truncated Taylor series on |x|/8, then ^8
    initial begin
        longint unsigned twice, span, u, term, e, den, s;
        longint          sum;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            twice = 64'(2 * i);
            span  = (twice >= SIG_DEPTH) ? twice - SIG_DEPTH : SIG_DEPTH - twice;
            u     = (span << 30) / SIG_DEPTH;
            term  = 64'd1 << 30;
            sum   = 64'sd1 <<< 30;
            for (int n = 1; n <= 20; n++) begin
                term = ((term * u) >> 30) / n;
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 1) sum = 1;
            if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
            e = longint'(sum);
            for (int k = 0; k < 3; k++) begin
                e = (e * e + (64'd1 << 29)) >> 30;
            end
            den = (64'd1 << 30) + e;
            s   = ((64'd1 << 46) + den / 2) / den;
            if (twice < SIG_DEPTH) s = 64'd65536 - s;
            sigmoid_rom[i] = s[15:0];
        end
    end

    function automatic t_act_beat swiglu_expect(t_q88 g, t_q88 l, logic last, t_q88 alpha);
        t_act_beat r;
        longint    p, prod, q;
        longint    idx;
        p = longint'(g) * longint'(alpha);
        if (p < ARG_LO) p = ARG_LO;
        if (p > ARG_HI) p = ARG_HI;
        idx = ((p - ARG_LO) * SIG_DEPTH) >>> 20;
        if (idx >= SIG_DEPTH) idx = SIG_DEPTH - 1;
        prod = longint'(g) * longint'(sigmoid_rom[idx]) * longint'(l);
        q = (prod + (64'sd1 <<< 23)) >>> 24;   // floor, halves round up
        r.sat = 1'b0;
        if (q > 32767) begin
            q = 32767;
            r.sat = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            r.sat = 1'b1;
        end
        r.value = q[15:0];
        r.last  = last;
        return r;
    endfunction

    // mostly back to back, some short gaps, rare long ones
    function automatic int idle_span();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(int sc, int g, int l, logic last, bit typed, int res, logic sat);
        t_stim_row row;
        row.scale = sc[15:0];
        row.gate  = g[15:0];
        row.lin   = l[15:0];
        row.last  = last;
        row.typed = typed;
        row.res   = res[15:0];
        row.sat   = sat;
        directed_rows.push_back(row);
    endtask

    task automatic offer_item(t_q88 g, t_q88 l, logic last, bit typed, t_act_beat typed_val);
        int gap;
        gap = idle_span();
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {l, g};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (typed) begin
            pending_results.push_back(typed_val);
        end else begin
            pending_results.push_back(swiglu_expect(g, l, last, gate_scale_q));
        end
    endtask

    task automatic drain_pipe();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_gate_scale(t_q88 v);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        gate_scale_q = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYC;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = idle_span();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_act_beat want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected beat value=%0d sat=%b last=%b", $realtime,
                             $signed(o_m_tdata), o_m_tuser, o_m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value || o_m_tuser !== want.sat ||
                    o_m_tlast !== want.last) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: mismatch exp %0d/%b/%b got %0d/%b/%b",
                                 $realtime, want.value, want.sat, want.last,
                                 $signed(o_m_tdata), o_m_tuser, o_m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        t_act_beat typed_val;
        t_q88      phase_scales[$];
        t_q88      g, l;
        logic      lst;
        int        sel, bnd, ag;

        // scale 1.0 from reset: zeros, saturation, clamp edges at +/-8
        add_row(256, 0, 0, 0, 1, 0, 0);
        add_row(256, 0, 32767, 1, 1, 0, 0);
        add_row(256, -32768, 0, 0, 1, 0, 0);
        add_row(256, 32767, 32767, 0, 1, 32767, 1);
        add_row(256, 32767, -32768, 1, 1, -32768, 1);
        add_row(256, -32768, 32767, 0, 0, 0, 0);
        add_row(256, -32768, -32768, 0, 0, 0, 0);
        add_row(256, 2048, 256, 0, 0, 0, 0);
        add_row(256, 2047, 256, 0, 0, 0, 0);
        add_row(256, -2048, 256, 0, 0, 0, 0);
        add_row(256, -2049, -256, 1, 0, 0, 0);
        add_row(256, 1, 1, 0, 1, 0, 0);
        add_row(256, 256, 256, 0, 0, 0, 0);
        add_row(256, -1, -1, 1, 0, 0, 0);
        // zero scale: sigmoid is exactly one half
        add_row(0, 256, 256, 0, 1, 128, 0);
        add_row(0, 32767, 32767, 0, 1, 32767, 1);
        add_row(0, -32768, 32767, 1, 1, -32768, 1);
        add_row(0, 512, -512, 0, 1, -512, 0);
        // extreme scales
        add_row(-32768, -32768, -32768, 0, 1, 32767, 1);
        add_row(-32768, 32767, 100, 0, 0, 0, 0);
        add_row(-32768, 1, 32767, 1, 0, 0, 0);
        add_row(32767, 128, -32768, 0, 0, 0, 0);
        add_row(32767, -1, 32767, 0, 0, 0, 0);
        add_row(1, 32767, 32767, 1, 0, 0, 0);
        add_row(1, -32768, 32767, 0, 0, 0, 0);

        phase_scales.push_back(16'sd256);
        phase_scales.push_back(16'sd0);
        phase_scales.push_back(16'sh7FFF);
        phase_scales.push_back(16'sh8000);
        phase_scales.push_back(16'sd1);
        phase_scales.push_back(-16'sd1);
        phase_scales.push_back(-16'sd256);
        phase_scales.push_back(16'sd128);
        phase_scales.push_back(16'sd1024);
        phase_scales.push_back(t_q88'($urandom_range(0, 65535)));
        phase_scales.push_back(t_q88'($urandom_range(0, 65535)));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.scale != gate_scale_q) write_gate_scale(row.scale);
            typed_val.value = row.res;
            typed_val.sat   = row.sat;
            typed_val.last  = row.last;
            offer_item(row.gate, row.lin, row.last, row.typed, typed_val);
        end

        foreach (phase_scales[ph]) begin
            write_gate_scale(phase_scales[ph]);
            quiet = (ph == 2 || ph == 7);
            if (ph == 3) hold_req = 1'b1;   // fill the pipe and back up the input
            for (int n = 0; n < PHASE_LEN; n++) begin
                sel = $urandom_range(0, 9);
                ag  = gate_scale_q;
                if (sel < 4) begin
                    g = t_q88'($urandom_range(0, 65535));
                end else if (sel < 7) begin
                    g = t_q88'($urandom_range(0, 2048) - 1024);
                end else if (sel == 7) begin
                    case ($urandom_range(0, 4))
                        0: g = 16'sh8000;
                        1: g = -16'sd1;
                        2: g = 16'sd0;
                        3: g = 16'sd1;
                        default: g = 16'sh7FFF;
                    endcase
                end else begin
                    // gate near the clamp boundary for this scale
                    bnd = (ag != 0) ? 524288 / ag : 65536;
                    if (bnd > 32767 || bnd < -32767) begin
                        g = t_q88'($urandom_range(0, 65535));
                    end else begin
                        bnd = bnd + $urandom_range(0, 4) - 2;
                        if ($urandom_range(0, 1) == 1) bnd = -bnd;
                        g = t_q88'(bnd);
                    end
                end
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: l = t_q88'($urandom_range(0, 65535));
                    4, 5, 6:    l = t_q88'($urandom_range(0, 4096) - 2048);
                    default:    l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                endcase
                lst = ($urandom_range(0, 7) == 0);
                offer_item(g, l, lst, 1'b0, typed_val);
            end
        end
        quiet = 1'b0;

        drain_pipe();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
